// ===== hdl/jht_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jht_pkg
// Shared types and constants for the joint homing trajectory unit.
// ----------------------------------------------------------------------------
package jht_pkg;
	localparam int MAX_JOINTS = 32;
	localparam int JW = (MAX_JOINTS > 1) ? $clog2(MAX_JOINTS) : 1;
	localparam int AJ_W = 6;
	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [2:0] KIND_LOAD = 3'd0;
	localparam logic [2:0] KIND_CAPTURE = 3'd1;
	localparam logic [2:0] KIND_START = 3'd2;
	localparam logic [2:0] KIND_TICK = 3'd3;
	localparam logic [2:0] KIND_CMD = 3'd4;

	localparam logic [1:0] MODE_STAY = 2'd0;
	localparam logic [1:0] MODE_ZERO = 2'd1;
	localparam logic [1:0] MODE_DAMP = 2'd2;
	localparam logic [1:0] MODE_OFF = 2'd3;

	localparam logic [1:0] REG_ACTIVE = 2'd0;
	localparam logic [1:0] REG_RAMP = 2'd1;
	localparam logic [1:0] REG_MOVE = 2'd2;

	typedef struct packed {
		logic [2:0] kind;
		logic [4:0] joint;
		logic signed [31:0] position;
		logic [31:0] stiffness;
		logic [31:0] damping;
		logic [15:0] tick_us;
		logic signed [7:0] key;
	} in_item_t;

	typedef struct packed {
		logic [4:0] out_joint;
		logic signed [31:0] target_position;
		logic [31:0] target_stiffness;
		logic [31:0] target_damping;
		logic last;
		logic [1:0] next_mode;
	} out_item_t;
endpackage

// ===== hdl/jht_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jht_in_if / jht_out_if
// Valid/ready channels for input and result beats.
// ----------------------------------------------------------------------------
interface jht_in_if import jht_pkg::*; ();
	logic valid;
	logic ready;
	in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface jht_out_if import jht_pkg::*; ();
	logic valid;
	logic ready;
	out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/jht_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jht_alu
// Shared 32x32 multiplier with registered product, plus a restoring divider
// (one quotient bit per cycle) for the progress value.
// ----------------------------------------------------------------------------
module jht_alu import jht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [31:0] mul_a,
	input  logic [31:0] mul_b,
	output logic [63:0] mul_p_q,
	input  logic        div_start,
	input  logic [31:0] div_num,
	input  logic [31:0] div_den,
	output logic        div_busy,
	output logic [16:0] div_q
);
	logic [31:0] rem_q;
	logic [47:0] quo_q;
	logic [5:0] cnt_q;
	logic [32:0] den_q;
	logic [32:0] trial;

	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_a) * 64'(mul_b);
	end

	// dividend = num << 16 (48 bits), shifted in msb first
	assign trial = {rem_q, quo_q[47]} - den_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (div_start) begin
			cnt_q <= 6'd48;
		end else if (cnt_q != 6'd0) begin
			cnt_q <= cnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			rem_q <= '0;
			quo_q <= {div_num, 16'd0};
			den_q <= {1'b0, div_den};
		end else if (cnt_q != 6'd0) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[46:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[47]};
				quo_q <= {quo_q[46:0], 1'b0};
			end
		end
	end

	assign div_busy = (cnt_q != 6'd0) || div_start;
	assign div_q = (quo_q[47:16] != 32'd0) ? ONE_Q16 : {1'b0, quo_q[15:0]};
endmodule

// ===== hdl/jht_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jht_regs
// APB register file: active_joints, ramp_time_us, move_time_us.
// ----------------------------------------------------------------------------
module jht_regs import jht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output logic [AJ_W-1:0] active_joints_q,
	output logic [31:0] ramp_time_q,
	output logic [31:0] move_time_q
);
	logic wr;
	logic [1:0] idx;
	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_joints_q <= AJ_W'(32);
			ramp_time_q <= 32'd1000000;
			move_time_q <= 32'd5000000;
		end else if (wr) begin
			unique case (idx)
				REG_ACTIVE: active_joints_q <= pwdata[AJ_W-1:0];
				REG_RAMP: ramp_time_q <= pwdata;
				REG_MOVE: move_time_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_ACTIVE: prdata = 32'(active_joints_q);
			REG_RAMP: prdata = ramp_time_q;
			REG_MOVE: prdata = move_time_q;
			default: prdata = '0;
		endcase
	end
endmodule

// ===== hdl/jht_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jht_seq
// Sequencer: table writes, command results, alpha computation through the
// shared unit, and the per-joint result walk.
// ----------------------------------------------------------------------------
module jht_seq import jht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	jht_in_if.sink      in_ch,
	jht_out_if.source   out_ch,
	input  logic [AJ_W-1:0] active_joints,
	input  logic [31:0] ramp_time,
	input  logic [31:0] move_time
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIV = 4'd1;
	localparam logic [3:0] ST_SQ = 4'd2;
	localparam logic [3:0] ST_CU = 4'd3;
	localparam logic [3:0] ST_P1 = 4'd4;
	localparam logic [3:0] ST_P2 = 4'd5;
	localparam logic [3:0] ST_AL = 4'd6;
	localparam logic [3:0] ST_RD = 4'd7;
	localparam logic [3:0] ST_MUL = 4'd8;
	localparam logic [3:0] ST_EMIT = 4'd9;
	localparam logic [3:0] ST_WAIT = 4'd10;
	localparam logic [3:0] ST_DWAIT = 4'd11;

	logic [31:0] home_mem [MAX_JOINTS];
	logic [31:0] stf_mem [MAX_JOINTS];
	logic [31:0] dmp_mem [MAX_JOINTS];
	logic [31:0] start_mem [MAX_JOINTS];

	logic [3:0] st_q;
	logic [31:0] elapsed_q;
	logic done_q;
	logic [1:0] phase_q;
	logic [15:0] tick_q;
	logic [16:0] s_q;
	logic [47:0] p_q;
	logic [33:0] c_q;
	logic [16:0] alpha_q;
	logic [5:0] n_q;
	logic [5:0] i_q;
	logic [31:0] home_r, stf_r, dmp_r, start_r;
	logic sign_q;
	logic [31:0] mag_q;
	out_item_t out_q;
	logic out_v_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic div_start, div_busy;
	logic [31:0] div_num, div_den;
	logic [16:0] div_q;
	logic [31:0] e_now;
	logic [32:0] esum;
	logic [5:0] n_lim;
	logic [1:0] cmd_mode;

	jht_alu u_alu (
		.clk(clk), .arst_n(arst_n), .mul_a(mul_a), .mul_b(mul_b), .mul_p_q(mul_p),
		.div_start(div_start), .div_num(div_num), .div_den(div_den),
		.div_busy(div_busy), .div_q(div_q)
	);

	wire acc = in_ch.valid && in_ch.ready;
	wire in_range = 32'(in_ch.data.joint) < 32'(MAX_JOINTS);
	assign in_ch.ready = (st_q == ST_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;
	assign e_now = elapsed_q - ramp_time;
	assign n_lim = (32'(active_joints) > 32'(MAX_JOINTS)) ? 6'(MAX_JOINTS) : active_joints;
	assign esum = {1'b0, elapsed_q} + 33'(tick_q);

	always_comb begin
		if (in_ch.data.key == 8'sd2 && done_q) cmd_mode = MODE_ZERO;
		else if (in_ch.data.key == 8'sd1) cmd_mode = MODE_DAMP;
		else if (in_ch.data.key == -8'sd1) cmd_mode = MODE_OFF;
		else cmd_mode = MODE_STAY;
	end

	always_comb begin
		div_num = elapsed_q;
		div_den = ramp_time;
		if (phase_q == 2'd1) begin
			div_num = e_now;
			div_den = move_time;
		end
		div_start = (st_q == ST_DIV) && (phase_q != 2'd2);
		mul_a = 32'(s_q);
		mul_b = 32'(s_q);
		unique case (st_q)
			ST_CU: begin mul_a = mul_p[31:0]; mul_b = 32'(s_q); end
			ST_P2: begin mul_a = 32'(c_q); mul_b = 32'(p_q[47:16]); end
			ST_MUL, ST_EMIT: begin
				mul_a = 32'(alpha_q);
				mul_b = (phase_q == 2'd0) ? stf_r : mag_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (acc && in_ch.data.kind == KIND_LOAD && in_range) begin
			home_mem[in_ch.data.joint[JW-1:0]] <= in_ch.data.position;
			stf_mem[in_ch.data.joint[JW-1:0]] <= in_ch.data.stiffness;
			dmp_mem[in_ch.data.joint[JW-1:0]] <= in_ch.data.damping;
		end
		if (acc && in_ch.data.kind == KIND_CAPTURE && in_range)
			start_mem[in_ch.data.joint[JW-1:0]] <= in_ch.data.position;
		home_r <= home_mem[i_q[JW-1:0]];
		stf_r <= stf_mem[i_q[JW-1:0]];
		dmp_r <= dmp_mem[i_q[JW-1:0]];
		start_r <= start_mem[i_q[JW-1:0]];
	end

	logic dgo_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			elapsed_q <= '0;
			done_q <= 1'b0;
			out_v_q <= 1'b0;
			phase_q <= '0;
			i_q <= '0;
			n_q <= '0;
			dgo_q <= 1'b0;
		end else begin
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			dgo_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (acc) begin
					tick_q <= in_ch.data.tick_us;
					unique case (in_ch.data.kind)
						KIND_START: begin elapsed_q <= '0; done_q <= 1'b0; end
						KIND_CMD: begin
							out_q <= {5'd0, 32'd0, 32'd0, 32'd0, 1'b1, cmd_mode};
							out_v_q <= 1'b1;
						end
						KIND_TICK: begin
							n_q <= n_lim;
							i_q <= '0;
							if (elapsed_q < ramp_time) phase_q <= 2'd0;
							else if (!done_q) phase_q <= 2'd1;
							else phase_q <= 2'd2;
							st_q <= ST_DIV;
							dgo_q <= 1'b1;
						end
						default: ;
					endcase
				end
				ST_DIV: begin
					if (phase_q == 2'd2) begin
						alpha_q <= ONE_Q16;
						st_q <= ST_RD;
					end else if (dgo_q) begin
						st_q <= ST_DWAIT;
					end
					if (phase_q == 2'd1 && e_now >= move_time) done_q <= 1'b1;
				end
				ST_DWAIT: if (!div_busy) begin
					s_q <= (div_den == 32'd0) ? ONE_Q16 : div_q;
					st_q <= ST_SQ;
				end
				ST_SQ: st_q <= ST_CU;
				ST_CU: begin
					p_q <= 48'(6 * 64'(mul_p[34:0])) + (48'd10 << 32) - 48'(15 * 64'(s_q) << 16);
					st_q <= ST_P1;
				end
				ST_P1: begin c_q <= mul_p[49:16]; st_q <= ST_P2; end
				ST_P2: st_q <= ST_AL;
				ST_AL: begin
					alpha_q <= (s_q == ONE_Q16 || mul_p[63:32] > 32'h10000) ? ONE_Q16
						: mul_p[48:32];
					st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_WAIT;
				ST_WAIT: begin
					sign_q <= $signed(home_r) < $signed(start_r);
					mag_q <= ($signed(home_r) < $signed(start_r)) ? start_r - home_r
						: home_r - start_r;
					st_q <= (n_q == 6'd0) ? ST_IDLE : ST_MUL;
					if (n_q == 6'd0) elapsed_q <= esum[32] ? 32'hFFFFFFFF : esum[31:0];
				end
				ST_MUL: st_q <= ST_EMIT;
				ST_EMIT: if (!out_v_q) begin
					out_q.out_joint <= 5'(i_q);
					out_q.target_damping <= dmp_r;
					out_q.last <= (i_q + 6'd1 == n_q);
					out_q.next_mode <= MODE_STAY;
					unique case (phase_q)
						2'd0: begin
							out_q.target_position <= start_r;
							out_q.target_stiffness <= mul_p[47:16];
						end
						2'd1: begin
							out_q.target_position <= sign_q ? start_r - mul_p[47:16]
								: start_r + mul_p[47:16];
							out_q.target_stiffness <= stf_r;
						end
						default: begin
							out_q.target_position <= home_r;
							out_q.target_stiffness <= stf_r;
						end
					endcase
					out_v_q <= 1'b1;
					if (i_q + 6'd1 == n_q) begin
						elapsed_q <= esum[32] ? 32'hFFFFFFFF : esum[31:0];
						st_q <= ST_IDLE;
					end else begin
						i_q <= i_q + 6'd1;
						st_q <= ST_RD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== hdl/joint_homing_trajectory_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joint_homing_trajectory_unit
// Homing trajectory generator: quintic stiffness ramp then quintic position blend.
// ----------------------------------------------------------------------------
// channel  dir  beat
// in_ch    in   load / capture / start / tick / command item
// out_ch   out  one joint result, or one command result
// apb      in   register writes and reads
// A ramp or blend tick runs the progress divide and the alpha polynomial, then
// walks the joints on the shared multiplier; a hold tick goes straight to the walk.
// Reset is asynchronous; tables are not cleared. Output stalls hold the walk.
module joint_homing_trajectory_unit import jht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	jht_in_if.sink      in_ch,
	jht_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	logic [AJ_W-1:0] active_joints;
	logic [31:0] ramp_time, move_time;

	jht_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.active_joints_q(active_joints), .ramp_time_q(ramp_time), .move_time_q(move_time)
	);

	jht_seq u_seq (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.active_joints(active_joints), .ramp_time(ramp_time), .move_time(move_time)
	);
endmodule

// ===== hdl/jht_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jht_checker
// Port-level checks on the trajectory unit.
// ----------------------------------------------------------------------------
module jht_checker import jht_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_item_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out hold");
	a_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.next_mode != MODE_STAY |-> out_data.last) else $error("cmd last");
	a_tick: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.next_mode != MODE_STAY |-> out_data.target_damping == 0)
		else $error("cmd fields");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid) else $error("accept while beat pending");
endmodule

bind joint_homing_trajectory_unit jht_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data)
);
